// File: rtl/bps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

   localparam int MAX_WIDTH  = 128;
   localparam int MAX_HEIGHT = 128;
   localparam int CHANNELS   = 3;
   localparam int FRAC_BITS  = 8;

   localparam int COEF_BITS  = 14;
   localparam int FRAC_STEPS = 1 << FRAC_BITS;
   localparam int WSHIFT     = 3 * FRAC_BITS + 2 - COEF_BITS;
   localparam int DEPTH      = CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int COORD_W    = 11;
   localparam int ACC_W      = 48;
   localparam int OUT_MIN    = -32768;
   localparam int OUT_MAX    = 98303;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_CLAMP  = 2'd2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef logic signed [15:0] coef_type;
   typedef coef_type coef_table_type [FRAC_STEPS];

   // keys kernel weights in q2.14, tap 3 taken as the remainder to 1.0
   function automatic coef_table_type build_weights(int tap);
      coef_table_type tbl;
      longint d, f, s, n0, n1, n2, w0, w1, w2, w3;
      d = longint'(FRAC_STEPS);
      for (int k = 0; k < FRAC_STEPS; k++) begin
         f  = longint'(k);
         s  = d - f;
         n0 = -3 * f * s * s;
         n1 = 5 * f * f * f - 9 * f * f * d + 4 * d * d * d;
         n2 = 5 * s * s * s - 9 * s * s * d + 4 * d * d * d;
         w0 = (n0 + (longint'(1) << (WSHIFT - 1))) >>> WSHIFT;
         w1 = (n1 + (longint'(1) << (WSHIFT - 1))) >>> WSHIFT;
         w2 = (n2 + (longint'(1) << (WSHIFT - 1))) >>> WSHIFT;
         w3 = (longint'(1) << COEF_BITS) - w0 - w1 - w2;
         if (tap == 0)
            tbl[k] = coef_type'(w0);
         else if (tap == 1)
            tbl[k] = coef_type'(w1);
         else if (tap == 2)
            tbl[k] = coef_type'(w2);
         else
            tbl[k] = coef_type'(w3);
      end
      return tbl;
   endfunction

endpackage

`default_nettype wire

// File: rtl/bicubic_pixel_sampler.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake               payload
// req      in         req_tvalid/req_tready   tdata: pos_x,pos_y,channel,pixel_value,frac_x,frac_y
//                                             tuser: operation
// rsp      out        rsp_tvalid/rsp_tready   tdata: sample_value
// csr      in         csr_we                  csr_index, csr_wdata
//
// a sample beat holds req_tready low through the sweep (the sixteen neighbour reads through
// the single image memory port) and the result state, so the next beat is taken only after
// its result has been registered. a sample on a channel outside the image skips the sweep.
// synchronous active-high reset clears control state; image memory is not cleared.
// loads are still taken while a finished sample waits on rsp_tready; a second finished
// sample waits in the result cycle, with req_tready low, until the first one leaves.

module bicubic_pixel_sampler (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pos_x[8:0] pos_y[17:9] channel[19:18] pixel_value[35:20] frac_x[43:36] frac_y[51:44]
   input  wire logic [55:0] req_tdata,
   // operation[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // sample_value[17:0]
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   import bps_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam coef_table_type W0_TBL = build_weights(0);
   localparam coef_table_type W1_TBL = build_weights(1);
   localparam coef_table_type W2_TBL = build_weights(2);
   localparam coef_table_type W3_TBL = build_weights(3);

   logic [15:0] image_mem [DEPTH];

   logic [1:0]                 st_ff, st_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic [7:0]                 width_ff, width_in;
   logic [7:0]                 height_ff, height_in;
   logic                       clamp_ff, clamp_in;
   logic signed [8:0]          px_ff, px_in;
   logic signed [8:0]          py_ff, py_in;
   logic [1:0]                 ch_ff, ch_in;
   logic [FRAC_BITS-1:0]       fx_ff, fx_in;
   logic [FRAC_BITS-1:0]       fy_ff, fy_in;
   logic signed [31:0]         wprod_ff, wprod_in;
   logic                       zero_ff, zero_in;
   logic                       v1_ff, v1_in;
   logic [15:0]                rdata_ff;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [17:0]                rsp_data_ff, rsp_data_in;

   logic                       req_acc;
   logic                       op;
   logic signed [8:0]          in_px, in_py;
   logic [1:0]                 in_ch;
   logic signed [COORD_W-1:0]  eff_w, eff_h, xs, ys, xc, yc;
   logic                       outside, load_ok, mem_we;
   logic [ADDR_W-1:0]          addr;
   coef_type                   wx, wy;
   logic signed [16:0]         pix_s;
   logic signed [ACC_W-1:0]    prod, rounded;
   logic [17:0]                result;

   assign op      = req_tuser[0];
   assign in_px   = req_tdata[8:0];
   assign in_py   = req_tdata[17:9];
   assign in_ch   = req_tdata[19:18];
   assign req_tready = (st_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;

   assign eff_w = (width_ff == 8'd0) ? COORD_W'(1) :
                  (32'(width_ff) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : COORD_W'(width_ff);
   assign eff_h = (height_ff == 8'd0) ? COORD_W'(1) :
                  (32'(height_ff) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : COORD_W'(height_ff);

   // neighbour coordinates for the current count
   assign xs = COORD_W'(px_ff) - COORD_W'(1) + $signed(COORD_W'(cnt_ff[1:0]));
   assign ys = COORD_W'(py_ff) - COORD_W'(1) + $signed(COORD_W'(cnt_ff[3:2]));
   assign outside = (xs < 0) || (xs >= eff_w) || (ys < 0) || (ys >= eff_h);

   always_comb begin
      xc = xs;
      yc = ys;
      if (st_ff == ST_IDLE) begin
         xc = COORD_W'(in_px);
         yc = COORD_W'(in_py);
      end else begin
         if (xs < 0) xc = '0;
         else if (xs >= eff_w) xc = eff_w - COORD_W'(1);
         if (ys < 0) yc = '0;
         else if (ys >= eff_h) yc = eff_h - COORD_W'(1);
      end
   end

   assign load_ok = (32'(in_ch) < CHANNELS) && (in_px >= 0) &&
                    (COORD_W'(in_px) < eff_w) && (in_py >= 0) && (COORD_W'(in_py) < eff_h);
   assign mem_we  = req_acc && (op == OP_LOAD) && load_ok;

   always_comb begin
      logic [1:0] ach;
      ach  = (st_ff == ST_IDLE) ? in_ch : ch_ff;
      addr = ADDR_W'(ach) * ADDR_W'(MAX_HEIGHT * MAX_WIDTH)
           + ADDR_W'(yc) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xc);
   end

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: wx = W0_TBL[fx_ff];
         2'd1: wx = W1_TBL[fx_ff];
         2'd2: wx = W2_TBL[fx_ff];
         default: wx = W3_TBL[fx_ff];
      endcase
      unique case (cnt_ff[3:2])
         2'd0: wy = W0_TBL[fy_ff];
         2'd1: wy = W1_TBL[fy_ff];
         2'd2: wy = W2_TBL[fy_ff];
         default: wy = W3_TBL[fy_ff];
      endcase
   end

   assign pix_s = $signed({1'b0, (zero_ff ? 16'd0 : rdata_ff)});
   assign prod  = ACC_W'(wprod_ff) * ACC_W'(pix_s);

   // round half up to pixel units, then saturate
   assign rounded = (acc_ff + (ACC_W'(1) <<< (2 * COEF_BITS))
                   / 2) >>> (2 * COEF_BITS);
   assign result  = (rounded < ACC_W'(OUT_MIN)) ? 18'(OUT_MIN) :
                    (rounded > ACC_W'(OUT_MAX)) ? 18'(OUT_MAX) : 18'(rounded);

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      clamp_in     = clamp_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ch_in        = ch_ff;
      fx_in        = fx_ff;
      fy_in        = fy_ff;
      wprod_in     = wprod_ff;
      zero_in      = zero_ff;
      v1_in        = 1'b0;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready)
         rsp_valid_in = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_CLAMP:  clamp_in  = csr_wdata[0];
            default: ;
         endcase
      end

      if (v1_ff)
         acc_in = acc_ff + prod;

      unique case (st_ff)
         ST_IDLE: begin
            if (req_acc && (op == OP_SAMPLE)) begin
               px_in  = in_px;
               py_in  = in_py;
               ch_in  = in_ch;
               fx_in  = req_tdata[36 +: FRAC_BITS];
               fy_in  = req_tdata[44 +: FRAC_BITS];
               acc_in = '0;
               cnt_in = '0;
               st_in  = (32'(in_ch) < CHANNELS) ? ST_RUN : ST_FIN;
            end
         end
         ST_RUN: begin
            if (cnt_ff[4]) begin
               st_in = ST_FIN;
            end else begin
               wprod_in = 32'(wx) * 32'(wy);
               zero_in  = !clamp_ff && outside;
               v1_in    = 1'b1;
               cnt_in   = cnt_ff + 5'd1;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         image_mem[addr] <= req_tdata[35:20];
      rdata_ff <= image_mem[addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         cnt_ff       <= '0;
         width_ff     <= 8'd128;
         height_ff    <= 8'd128;
         clamp_ff     <= 1'b1;
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         clamp_ff     <= clamp_in;
         v1_ff        <= v1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff       <= px_in;
      py_ff       <= py_in;
      ch_ff       <= ch_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      wprod_ff    <= wprod_in;
      zero_ff     <= zero_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_RUN) |-> (cnt_ff <= 5'd16))
      else $error("neighbour count overran");

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_FIN && rsp_valid_ff && !rsp_tready) |=> (st_ff == ST_FIN))
      else $error("finished sample dropped while output busy");

   a_sample_start: assert property (@(posedge clock) disable iff (reset)
      (req_acc && op == OP_SAMPLE && 32'(in_ch) < CHANNELS) |=>
         (st_ff == ST_RUN && cnt_ff == 5'd0 && acc_ff == '0))
      else $error("sample did not start its neighbour sweep");

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import bps_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   bicubic_pixel_sampler u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow image, configuration and expected samples
   logic [15:0]       pix_mem [DEPTH];
   bit                pix_written [DEPTH];
   int                img_w = 128, img_h = 128;
   bit                clamp_on = 1'b1;
   logic signed [17:0] sample_q [$];
   int                errors = 0;
   int                n_loads = 0, n_samples = 0, n_checked = 0;
   int                idle_cycles = 0;
   bit                rsp_hold = 1'b0;
   bit                rsp_gaps = 1'b1;
   bit                req_gaps = 1'b1;

   function automatic longint rnd_half_up(longint v, int sh);
      longint q;
      v = v + (longint'(1) << (sh - 1));
      q = v >>> sh;
      return q;
   endfunction

   function automatic void kernel_taps(int frac, output longint w[4]);
      longint d, f, s, n0, n1, n2;
      d = FRAC_STEPS;
      f = frac;
      s = d - f;
      n0 = -3 * f * s * s;
      n1 = 5 * f * f * f - 9 * f * f * d + 4 * d * d * d;
      n2 = 5 * s * s * s - 9 * s * s * d + 4 * d * d * d;
      w[0] = rnd_half_up(n0, WSHIFT);
      w[1] = rnd_half_up(n1, WSHIFT);
      w[2] = rnd_half_up(n2, WSHIFT);
      w[3] = (longint'(1) << COEF_BITS) - w[0] - w[1] - w[2];
   endfunction

   function automatic int pix_addr(int x, int y, int ch);
      return (ch * MAX_HEIGHT + y) * MAX_WIDTH + x;
   endfunction

   // neighbour read with edge policy; -1 flags an unwritten entry
   function automatic longint neighbour(int x, int y, int ch);
      if (clamp_on) begin
         if (x < 0) x = 0;
         if (x > img_w - 1) x = img_w - 1;
         if (y < 0) y = 0;
         if (y > img_h - 1) y = img_h - 1;
      end else if (x < 0 || x >= img_w || y < 0 || y >= img_h) begin
         return 0;
      end
      if (!pix_written[pix_addr(x, y, ch)]) return -1;
      return pix_mem[pix_addr(x, y, ch)];
   endfunction

   function automatic bit all_known(int px, int py, int ch);
      if (ch >= CHANNELS) return 1'b1;
      for (int j = 0; j < 4; j++)
         for (int i = 0; i < 4; i++)
            if (neighbour(px - 1 + i, py - 1 + j, ch) < 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic signed [17:0] interp_sample(int px, int py, int ch, int fx, int fy);
      longint wx[4], wy[4], acc, row, r;
      if (ch >= CHANNELS) return '0;
      kernel_taps(fx, wx);
      kernel_taps(fy, wy);
      acc = 0;
      for (int j = 0; j < 4; j++) begin
         row = 0;
         for (int i = 0; i < 4; i++)
            row += wx[i] * neighbour(px - 1 + i, py - 1 + j, ch);
         acc += wy[j] * row;
      end
      r = rnd_half_up(acc, 2 * COEF_BITS);
      if (r < OUT_MIN) r = OUT_MIN;
      if (r > OUT_MAX) r = OUT_MAX;
      return 18'(r);
   endfunction

   // valid drops only when a gap is really taken
   task automatic rand_gap(bit on);
      int n;
      if (!on) return;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if (n != 0) req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // send one beat and update the shadow image or the expected samples
   task automatic send_beat(bit op, int px, int py, int ch, int val, int fx, int fy);
      rand_gap(req_gaps);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, 8'(fy), 8'(fx), 16'(val), 2'(ch), 9'(py), 9'(px)};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         n_loads++;
         if (ch < CHANNELS && px >= 0 && px < img_w && py >= 0 && py < img_h) begin
            pix_mem[pix_addr(px, py, ch)] = 16'(val);
            pix_written[pix_addr(px, py, ch)] = 1'b1;
         end
      end else begin
         n_samples++;
         sample_q.push_back(interp_sample(px, py, ch, fx, fy));
      end
   endtask

   task automatic load_pix(int px, int py, int ch, int val);
      send_beat(OP_LOAD, px, py, ch, val, $urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // a sample whose neighbourhood is fully written, or rejected
   task automatic try_sample(int px, int py, int ch, int fx, int fy);
      if (all_known(px, py, ch)) send_beat(OP_SAMPLE, px, py, ch, $urandom, fx, fy);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sample_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, int val);
      req_tvalid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 8'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_WIDTH) img_w = (val < 1) ? 1 : (val > MAX_WIDTH ? MAX_WIDTH : val);
      else if (idx == CSR_HEIGHT) img_h = (val < 1) ? 1 : (val > MAX_HEIGHT ? MAX_HEIGHT : val);
      else clamp_on = val[0];
   endtask

   task automatic set_image(int w, int h, bit c);
      drain();
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_CLAMP, c);
   endtask

   // fill a w x h block of every channel
   task automatic fill_block(int w, int h, bit extremes);
      for (int ch = 0; ch < CHANNELS; ch++)
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
               load_pix(x, y, ch, extremes ? ((x + y) % 2 ? 16'hFFFF : 0) : $urandom_range(0, 65535));
   endtask

   task automatic test_directed();
      set_image(4, 4, 1'b1);
      fill_block(4, 4, 1'b1);
      try_sample(1, 1, 0, 0, 0);
      try_sample(1, 1, 1, 255, 255);
      try_sample(2, 2, 2, 128, 128);
      try_sample(-256, -256, 0, 200, 17);
      try_sample(255, 255, 1, 255, 0);
      try_sample(0, 0, 3, 99, 99);
      load_pix(-1, 0, 0, 16'h1234);
      load_pix(4, 4, 0, 16'h1234);
      load_pix(0, 0, 3, 16'h1234);
      load_pix(255, -256, 1, 16'hFFFF);
      drain();
      write_csr(CSR_CLAMP, 0);
      try_sample(0, 0, 0, 255, 255);
      try_sample(3, 3, 2, 1, 254);
      try_sample(100, 100, 1, 0, 0);
      set_image(0, 255, 1'b1);
      try_sample(0, 0, 0, 128, 64);
      try_sample(-5, 200, 2, 7, 250);
   endtask

   task automatic test_random(int n, int w, int h, bit c);
      set_image(w, h, c);
      fill_block(w > 8 ? 8 : w, h > 8 ? 8 : h, 1'b0);
      // only the written corner, at most 8x8, is ever read
      if (w > 8) img_w = 8;
      if (h > 8) img_h = 8;
      write_csr(CSR_WIDTH, img_w);
      write_csr(CSR_HEIGHT, img_h);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 4) == 0)
            load_pix($urandom_range(0, 511) - 256 + (($urandom_range(0, 1)) ? 256 : 0) % 512,
                     $urandom_range(0, 9) - 1, $urandom_range(0, 3), $urandom_range(0, 65535));
         else
            try_sample($urandom_range(0, 511) - 256, $urandom_range(0, 511) - 256,
                       $urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 255));
         if ($urandom_range(0, 7) == 0)
            try_sample($urandom_range(0, 12) - 2, $urandom_range(0, 12) - 2,
                       $urandom_range(0, 2), $urandom_range(0, 255), $urandom_range(0, 255));
      end
   endtask

   task automatic test_backpressure();
      drain();
      req_gaps = 1'b0;
      rsp_hold = 1'b1;
      for (int k = 0; k < 12; k++)
         try_sample($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 2),
                    $urandom_range(0, 255), $urandom_range(0, 255));
      req_gaps = 1'b1;
   endtask

   // long receiver hold-off counted here
   initial begin
      wait (rsp_hold);
      repeat (400) @(posedge clock);
      rsp_hold = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || rsp_hold) rsp_tready <= 1'b0;
      else if (rsp_gaps) rsp_tready <= ($urandom_range(0, 3) != 0);
      else rsp_tready <= 1'b1;
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_checked++;
         if (sample_q.size() == 0) begin
            $error("unexpected beat sample_value actual %0d", $signed(rsp_tdata[17:0]));
            errors++;
         end else begin
            logic signed [17:0] want;
            want = sample_q.pop_front();
            if (rsp_tdata[17:0] !== want) begin
               $error("sample_value expected %0d actual %0d", want, $signed(rsp_tdata[17:0]));
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("bicubic_pixel_sampler verification failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(150, 128, 128, 1'b1);
      test_random(150, 5, 7, 1'b0);
      test_backpressure();
      test_random(150, 1, 1, 1'b1);
      rsp_gaps = 1'b0;
      test_random(150, 128, 4, 1'b0);
      rsp_gaps = 1'b1;
      test_random(150, 6, 128, 1'b1);
      drain();
      $display("ran %0d loads and %0d samples, %0d results checked", n_loads, n_samples,
               n_checked);
      $display("covered clamped and zero edges, sizes from 1 to 128, receiver hold-off");
      if (errors == 0 && sample_q.size() == 0) begin
         $display("bicubic_pixel_sampler verification clean");
      end else begin
         $display("bicubic_pixel_sampler verification failed");
      end
      $finish;
   end

endmodule
